[rtl/core/tpag_pkg.sv]
// ----------------------------------------------------------------------------
// Tensor permute address generator package
// Shared types, register indexes and reset values for the address generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpag_pkg;

   localparam int CSR_DATA_BITS     = 60;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int MAP_SLOT_BITS     = 3;
   localparam int MAP_BITS          = 18;
   localparam int ELEM_BITS         = 4;
   localparam int NUM_DIMS_BITS     = 3;
   localparam int OFFSET_FIELD_BITS = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_DIMS      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_SHAPE     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_MAP      = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ELEMENT_BYTES = 2'd3;

   localparam logic [NUM_DIMS_BITS-1:0] NUM_DIMS_RESET      = 3'd1;
   localparam logic [CSR_DATA_BITS-1:0] DST_SHAPE_RESET     = 60'd1127000493261825;
   localparam logic [MAP_BITS-1:0]      AXIS_MAP_RESET      = 18'd181896;
   localparam logic [ELEM_BITS-1:0]     ELEMENT_BYTES_RESET = 4'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STRIDE,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic init_load;
      logic advance;
      logic clear_started;
      logic stride_step;
      logic accum_init;
      logic accum_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bad_map;
      logic started;
      logic stride_last;
      logic accum_last;
   } status_type;

   typedef struct packed {
      logic restart;
   } req_payload_type;

   typedef struct packed {
      logic [OFFSET_FIELD_BITS-1:0] src_offset;
      logic [OFFSET_FIELD_BITS-1:0] dst_offset;
      logic                         last_element;
      logic                         bad_config;
   } rsp_payload_type;

endpackage

`default_nettype wire

[rtl/core/tpag_if.sv]
// ----------------------------------------------------------------------------
// Tensor permute address generator channels
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpag_req_if;
   import tpag_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tpag_rsp_if;
   import tpag_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/tpag_ctrl.sv]
// ----------------------------------------------------------------------------
// Tensor permute address generator controller
// Sequences stride setup, position accumulation and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tpag_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_restart,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire tpag_pkg::status_type status,
   output tpag_pkg::cmd_type        cmd
);
   import tpag_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.bad_map) begin
                  state_in = ST_FINISH;
               end else if (req_restart || !status.started) begin
                  state_in = ST_STRIDE;
               end else begin
                  state_in = ST_ACCUM;
               end
            end
         end
         ST_STRIDE: begin
            if (status.stride_last) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (status.accum_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (status.bad_map) begin
                  cmd.clear_started = 1'b1;
               end else if (req_restart || !status.started) begin
                  cmd.init_load = 1'b1;
               end else begin
                  cmd.advance    = 1'b1;
                  cmd.accum_init = 1'b1;
               end
            end
         end
         ST_STRIDE: begin
            cmd.stride_step = 1'b1;
            cmd.accum_init  = status.stride_last;
         end
         ST_ACCUM: begin
            cmd.accum_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new response may only overwrite the output register once it is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over a pending transaction");

   // Stride setup always follows a load that marks the walk as started.
   a_stride_started: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STRIDE) |-> status.started)
      else $error("stride setup without a started walk");

   a_first_item_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && !status.bad_map && !status.started) |=> (state_ff == ST_STRIDE))
      else $error("first item of a walk skipped stride setup");

endmodule

`default_nettype wire

[rtl/core/tpag_dp.sv]
// ----------------------------------------------------------------------------
// Tensor permute address generator datapath
// Stride tables, axis odometer, position accumulators and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpag_dp #(
   parameter int MAX_DIMS    = 6,
   parameter int DIM_BITS    = 10,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tpag_pkg::cmd_type                     cmd,
   output tpag_pkg::status_type                       status,
   input  wire logic [tpag_pkg::NUM_DIMS_BITS-1:0]    num_dims,
   input  wire logic [tpag_pkg::CSR_DATA_BITS-1:0]    dst_shape,
   input  wire logic [tpag_pkg::MAP_BITS-1:0]         axis_map,
   input  wire logic [tpag_pkg::ELEM_BITS-1:0]        element_bytes,
   output tpag_pkg::rsp_payload_type                  rsp_data
);
   import tpag_pkg::*;

   localparam int IW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CW    = $clog2(MAX_DIMS + 1);
   localparam int PW    = (OFFSET_BITS < OFFSET_FIELD_BITS) ? OFFSET_BITS : OFFSET_FIELD_BITS;
   localparam int PRODW = PW + DIM_BITS;
   localparam int SCALW = PW + ELEM_BITS;

   logic [PW-1:0]       src_stride_ff [MAX_DIMS];
   logic [PW-1:0]       src_stride_in [MAX_DIMS];
   logic [PW-1:0]       dst_stride_ff [MAX_DIMS];
   logic [PW-1:0]       dst_stride_in [MAX_DIMS];
   logic [DIM_BITS-1:0] idx_ff        [MAX_DIMS];
   logic [DIM_BITS-1:0] idx_in        [MAX_DIMS];
   logic [DIM_BITS-1:0] adv_idx       [MAX_DIMS];

   logic [PW-1:0]       ss_ff, ss_in, ds_ff, ds_in;
   logic [PW-1:0]       src_prod_ff, src_prod_in, dst_prod_ff, dst_prod_in;
   logic [PW-1:0]       src_acc_ff, src_acc_in, dst_acc_ff, dst_acc_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                started_ff, started_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic [CW-1:0]            n;
   logic                     bad_map;
   logic                     carry;
   logic                     last_flag;
   logic [CW-1:0]            stride_pos;
   logic [IW-1:0]            stride_i;
   logic [MAP_SLOT_BITS-1:0] map_m;
   logic [IW-1:0]            map_idx;
   logic [IW-1:0]            acc_idx;
   logic [PRODW-1:0]         ss_prod, ds_prod, src_mac, dst_mac;
   logic [SCALW-1:0]         src_scaled, dst_scaled;
   logic [ELEM_BITS-1:0]     eb_eff;

   // Axis size with an empty slot treated as one.
   function automatic logic [DIM_BITS-1:0] axis_size(input logic [CSR_DATA_BITS-1:0] shape,
                                                     input int d);
      logic [DIM_BITS-1:0] s;
      s = shape[d*DIM_BITS +: DIM_BITS];
      return (s == '0) ? DIM_BITS'(1) : s;
   endfunction

   always_comb begin
      if (num_dims == '0) begin
         n = CW'(1);
      end else if (num_dims > NUM_DIMS_BITS'(MAX_DIMS)) begin
         n = CW'(MAX_DIMS);
      end else begin
         n = CW'(num_dims);
      end
   end

   // The mapping is good only when every used slot names a distinct used axis.
   always_comb begin
      bad_map = 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (CW'(i) < n) begin
            if ({1'b0, axis_map[i*MAP_SLOT_BITS +: MAP_SLOT_BITS]} >= (MAP_SLOT_BITS+1)'(n)) begin
               bad_map = 1'b1;
            end
            for (int j = 0; j < i; j++) begin
               if (axis_map[j*MAP_SLOT_BITS +: MAP_SLOT_BITS] ==
                   axis_map[i*MAP_SLOT_BITS +: MAP_SLOT_BITS]) begin
                  bad_map = 1'b1;
               end
            end
         end
      end
   end

   // Odometer step: the innermost used axis moves fastest.
   always_comb begin
      carry = 1'b1;
      for (int d = MAX_DIMS - 1; d >= 0; d--) begin
         adv_idx[d] = idx_ff[d];
         if ((CW'(d) < n) && carry) begin
            if ((DIM_BITS+1)'(idx_ff[d]) + (DIM_BITS+1)'(1) <
                (DIM_BITS+1)'(axis_size(dst_shape, d))) begin
               adv_idx[d] = idx_ff[d] + DIM_BITS'(1);
               carry      = 1'b0;
            end else begin
               adv_idx[d] = '0;
            end
         end
      end
   end

   always_comb begin
      last_flag = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if ((CW'(d) < n) && ((DIM_BITS+1)'(idx_ff[d]) + (DIM_BITS+1)'(1) !=
                              (DIM_BITS+1)'(axis_size(dst_shape, d)))) begin
            last_flag = 1'b0;
         end
      end
   end

   // Strides are built from the innermost axis outward, one axis per cycle.
   assign stride_pos = n - CW'(1) - cnt_ff;
   assign stride_i   = stride_pos[IW-1:0];
   assign map_m      = axis_map[stride_i*MAP_SLOT_BITS +: MAP_SLOT_BITS];
   assign map_idx    = map_m[IW-1:0];
   assign ss_prod    = PRODW'(ss_ff) * PRODW'(axis_size(dst_shape, int'(map_m)));
   assign ds_prod    = PRODW'(ds_ff) * PRODW'(axis_size(dst_shape, int'(stride_i)));

   assign acc_idx    = cnt_ff[IW-1:0];
   assign src_mac    = PRODW'(idx_ff[acc_idx]) * PRODW'(src_stride_ff[acc_idx]);
   assign dst_mac    = PRODW'(idx_ff[acc_idx]) * PRODW'(dst_stride_ff[acc_idx]);

   assign eb_eff     = (element_bytes == '0) ? ELEM_BITS'(1) : element_bytes;
   assign src_scaled = SCALW'(src_acc_ff) * SCALW'(eb_eff);
   assign dst_scaled = SCALW'(dst_acc_ff) * SCALW'(eb_eff);

   assign status.bad_map     = bad_map;
   assign status.started     = started_ff;
   assign status.stride_last = (cnt_ff == n - CW'(1));
   assign status.accum_last  = (cnt_ff == n);

   always_comb begin
      started_in    = started_ff;
      cnt_in        = cnt_ff;
      ss_in         = ss_ff;
      ds_in         = ds_ff;
      src_stride_in = src_stride_ff;
      dst_stride_in = dst_stride_ff;
      idx_in        = idx_ff;
      src_prod_in   = src_prod_ff;
      dst_prod_in   = dst_prod_ff;
      src_acc_in    = src_acc_ff;
      dst_acc_in    = dst_acc_ff;
      rsp_in        = rsp_ff;

      if (cmd.init_load) begin
         started_in = 1'b1;
         cnt_in     = '0;
         ss_in      = PW'(1);
         ds_in      = PW'(1);
         for (int k = 0; k < MAX_DIMS; k++) begin
            src_stride_in[k] = PW'(1);
            dst_stride_in[k] = PW'(1);
            idx_in[k]        = '0;
         end
      end
      if (cmd.clear_started) started_in = 1'b0;
      if (cmd.advance) idx_in = adv_idx;

      if (cmd.stride_step) begin
         src_stride_in[map_idx]  = ss_ff;
         dst_stride_in[stride_i] = ds_ff;
         ss_in  = ss_prod[PW-1:0];
         ds_in  = ds_prod[PW-1:0];
         cnt_in = cnt_ff + CW'(1);
      end

      if (cmd.accum_step) begin
         src_acc_in = src_acc_ff + src_prod_ff;
         dst_acc_in = dst_acc_ff + dst_prod_ff;
         cnt_in     = cnt_ff + CW'(1);
         if (status.accum_last) begin
            src_prod_in = '0;
            dst_prod_in = '0;
         end else begin
            src_prod_in = src_mac[PW-1:0];
            dst_prod_in = dst_mac[PW-1:0];
         end
      end

      if (cmd.accum_init) begin
         cnt_in      = '0;
         src_prod_in = '0;
         dst_prod_in = '0;
         src_acc_in  = '0;
         dst_acc_in  = '0;
      end

      if (cmd.out_load) begin
         if (bad_map) begin
            rsp_in.src_offset   = '0;
            rsp_in.dst_offset   = '0;
            rsp_in.last_element = 1'b0;
            rsp_in.bad_config   = 1'b1;
         end else begin
            rsp_in.src_offset   = OFFSET_FIELD_BITS'(src_scaled[PW-1:0]);
            rsp_in.dst_offset   = OFFSET_FIELD_BITS'(dst_scaled[PW-1:0]);
            rsp_in.last_element = last_flag;
            rsp_in.bad_config   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         started_ff <= started_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ss_ff         <= ss_in;
      ds_ff         <= ds_in;
      src_stride_ff <= src_stride_in;
      dst_stride_ff <= dst_stride_in;
      idx_ff        <= idx_in;
      src_prod_ff   <= src_prod_in;
      dst_prod_ff   <= dst_prod_in;
      src_acc_ff    <= src_acc_in;
      dst_acc_ff    <= dst_acc_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/tensor_permute_address_generator_unit.sv]
// ----------------------------------------------------------------------------
// Tensor permute address generator
// Produces source/destination byte offset pairs for a permuted tensor copy.
// ----------------------------------------------------------------------------
// Each request transaction on req_bus carries a restart bit; each one yields
// exactly one response transaction on rsp_bus with the source and destination
// byte offsets, a last-element flag and a bad-configuration flag.
// The user must write registers through csr_wr_en/csr_index/csr_wdata only
// while idle; the block itself does not enforce this.
// A restart (or the first item of a walk) builds the strides, then sums the
// index times stride products, handling one axis per cycle in each step; an
// advance steps the odometer and sums the products with the strides it has;
// a bad mapping skips both steps, loads a bad-configuration response and
// clears the walk.
// The response waits in an output register; a new request is taken once the
// previous response has been loaded, so a stalled receiver only holds back
// the final load of the next response.
// Reset returns the registers to their defaults and clears the walk, so the
// first request after reset always starts at the first element.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_permute_address_generator_unit #(
   parameter int MAX_DIMS    = 6,
   parameter int DIM_BITS    = 10,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tpag_req_if.sink                                 req_bus,
   tpag_rsp_if.source                               rsp_bus,
   input  wire logic                                csr_wr_en,
   input  wire logic [tpag_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [tpag_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tpag_pkg::*;

   logic [NUM_DIMS_BITS-1:0] num_dims_ff, num_dims_in;
   logic [CSR_DATA_BITS-1:0] dst_shape_ff, dst_shape_in;
   logic [MAP_BITS-1:0]      axis_map_ff, axis_map_in;
   logic [ELEM_BITS-1:0]     element_bytes_ff, element_bytes_in;

   cmd_type         cmd;
   status_type      status;
   rsp_payload_type rsp_data;

   always_comb begin
      num_dims_in      = num_dims_ff;
      dst_shape_in     = dst_shape_ff;
      axis_map_in      = axis_map_ff;
      element_bytes_in = element_bytes_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_DIMS:      num_dims_in      = csr_wdata[NUM_DIMS_BITS-1:0];
            CSR_DST_SHAPE:     dst_shape_in     = csr_wdata;
            CSR_AXIS_MAP:      axis_map_in      = csr_wdata[MAP_BITS-1:0];
            CSR_ELEMENT_BYTES: element_bytes_in = csr_wdata[ELEM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff      <= NUM_DIMS_RESET;
         dst_shape_ff     <= DST_SHAPE_RESET;
         axis_map_ff      <= AXIS_MAP_RESET;
         element_bytes_ff <= ELEMENT_BYTES_RESET;
      end else begin
         num_dims_ff      <= num_dims_in;
         dst_shape_ff     <= dst_shape_in;
         axis_map_ff      <= axis_map_in;
         element_bytes_ff <= element_bytes_in;
      end
   end

   tpag_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_restart (req_bus.data.restart),
      .req_ready   (req_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   tpag_dp #(
      .MAX_DIMS    (MAX_DIMS),
      .DIM_BITS    (DIM_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .num_dims      (num_dims_ff),
      .dst_shape     (dst_shape_ff),
      .axis_map      (axis_map_ff),
      .element_bytes (element_bytes_ff),
      .rsp_data      (rsp_data)
   );

   assign rsp_bus.data = rsp_data;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Tensor permute address generator testbench
// Drives restart/advance request transactions into the address generator and
// checks every response transaction against a directed row's fixed value or
// a cycle-free model of the permuted odometer walk. A short table of directed
// rows comes first, then random register settings and walks under several
// patterns of sender gaps and receiver stalls, including one long hold-off.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tpag_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int AXES          = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 20;
   localparam int PHASES        = 8;
   localparam int BLOCKS        = 5;
   localparam int BLOCK_ITEMS   = 26;

   typedef struct packed {
      logic [NUM_DIMS_BITS-1:0] dims;
      logic [CSR_DATA_BITS-1:0] shape;
      logic [MAP_BITS-1:0]      amap;
      logic [ELEM_BITS-1:0]     ebytes;
      logic                     restart;
      logic                     typed;
      rsp_payload_type          exp;
   } directed_row_type;

   localparam rsp_payload_type RSP_LAST = '{32'd0, 32'd0, 1'b1, 1'b0};
   localparam rsp_payload_type RSP_BAD  = '{32'd0, 32'd0, 1'b0, 1'b1};
   localparam rsp_payload_type RSP_ZERO = '{32'd0, 32'd0, 1'b0, 1'b0};

   localparam logic [CSR_DATA_BITS-1:0] SH_3X4  = {40'd0, 10'd4, 10'd3};
   localparam logic [CSR_DATA_BITS-1:0] SH_4    = {50'd0, 10'd4};
   localparam logic [CSR_DATA_BITS-1:0] SH_5    = {50'd0, 10'd5};
   localparam logic [CSR_DATA_BITS-1:0] SH_ZERO = 60'd0;
   localparam logic [CSR_DATA_BITS-1:0] SH_MAX  = {60{1'b1}};
   localparam logic [CSR_DATA_BITS-1:0] SH_MID  = {10'd2, {5{10'd1023}}};

   localparam logic [MAP_BITS-1:0] MAP_OUT  = 18'o543215;
   localparam logic [MAP_BITS-1:0] MAP_DUP  = 18'o000011;
   localparam logic [MAP_BITS-1:0] MAP_SWAP = 18'o000001;
   localparam logic [MAP_BITS-1:0] MAP_REV  = 18'o012345;
   localparam logic [MAP_BITS-1:0] MAP_ONES = 18'o777777;

   localparam int DIRECTED_COUNT = 24;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // After reset: an advance before any start behaves as a restart.
      '{3'd1, DST_SHAPE_RESET, AXIS_MAP_RESET, 4'd1, 1'b0, 1'b1, RSP_LAST},
      '{3'd1, DST_SHAPE_RESET, AXIS_MAP_RESET, 4'd1, 1'b0, 1'b1, RSP_LAST},
      // Mappings that are not permutations: out of range and duplicated.
      '{3'd2, SH_3X4, MAP_OUT,  4'd1, 1'b1, 1'b1, RSP_BAD},
      '{3'd2, SH_3X4, MAP_DUP,  4'd1, 1'b0, 1'b1, RSP_BAD},
      '{3'd2, SH_3X4, MAP_DUP,  4'd1, 1'b1, 1'b1, RSP_BAD},
      // A bad mapping clears the walk, so the next advance starts over.
      '{3'd2, SH_3X4, MAP_SWAP, 4'd1, 1'b0, 1'b0, RSP_ZERO},
      '{3'd2, SH_3X4, MAP_SWAP, 4'd1, 1'b0, 1'b0, RSP_ZERO},
      '{3'd2, SH_3X4, MAP_SWAP, 4'd1, 1'b0, 1'b0, RSP_ZERO},
      '{3'd2, SH_3X4, MAP_SWAP, 4'd1, 1'b0, 1'b0, RSP_ZERO},
      '{3'd2, SH_3X4, MAP_SWAP, 4'd1, 1'b1, 1'b0, RSP_ZERO},
      // Zero axis count is taken as one axis.
      '{3'd0, SH_4,   AXIS_MAP_RESET, 4'd2, 1'b1, 1'b0, RSP_ZERO},
      '{3'd0, SH_4,   AXIS_MAP_RESET, 4'd2, 1'b0, 1'b0, RSP_ZERO},
      // Zero axis size is taken as size one.
      '{3'd1, SH_ZERO, AXIS_MAP_RESET, 4'd2, 1'b1, 1'b1, RSP_LAST},
      // Zero element size, then the largest element size code.
      '{3'd1, SH_5,   AXIS_MAP_RESET, 4'd0,  1'b1, 1'b0, RSP_ZERO},
      '{3'd1, SH_5,   AXIS_MAP_RESET, 4'd0,  1'b0, 1'b0, RSP_ZERO},
      '{3'd1, SH_5,   AXIS_MAP_RESET, 4'd15, 1'b0, 1'b0, RSP_ZERO},
      // Axis count above the maximum, every axis at its largest size.
      '{3'd7, SH_MAX, AXIS_MAP_RESET, 4'd8, 1'b1, 1'b1, RSP_ZERO},
      '{3'd7, SH_MAX, AXIS_MAP_RESET, 4'd8, 1'b0, 1'b0, RSP_ZERO},
      '{3'd7, SH_MAX, AXIS_MAP_RESET, 4'd8, 1'b0, 1'b0, RSP_ZERO},
      '{3'd7, SH_MAX, AXIS_MAP_RESET, 4'd8, 1'b0, 1'b0, RSP_ZERO},
      // Shape and axis count changed in the middle of a walk.
      '{3'd7, SH_MID, AXIS_MAP_RESET, 4'd8, 1'b0, 1'b0, RSP_ZERO},
      '{3'd3, SH_MID, AXIS_MAP_RESET, 4'd8, 1'b0, 1'b0, RSP_ZERO},
      '{3'd6, SH_ZERO, MAP_REV,  4'd8, 1'b1, 1'b1, RSP_LAST},
      '{3'd6, SH_ZERO, MAP_ONES, 4'd9, 1'b0, 1'b1, RSP_BAD}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   tpag_req_if req_bus();
   tpag_rsp_if rsp_bus();

   tensor_permute_address_generator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Register copies and walk state of the model.
   logic [NUM_DIMS_BITS-1:0] cfg_num_dims;
   logic [CSR_DATA_BITS-1:0] cfg_shape;
   logic [MAP_BITS-1:0]      cfg_map;
   logic [ELEM_BITS-1:0]     cfg_elem;
   logic [31:0]              stride_src [AXES];
   logic [31:0]              stride_dst [AXES];
   logic [9:0]               axis_pos [AXES];
   logic                     walk_on;

   rsp_payload_type expected_offsets [$];
   rsp_payload_type predicted;
   rsp_payload_type want;
   rsp_payload_type got;
   rsp_payload_type typed_rsp;
   logic            typed_armed;

   int fail_count;
   int requests_sent;
   int responses_checked;
   int walks_finished;
   int bad_maps_flagged;
   int send_idle_pct;
   int rcv_stall_pct;
   int hold_requests;
   int holds_done;
   int hold_left;
   int cycle_count;

   function automatic logic [31:0] axis_size(input int d);
      logic [9:0] slot;
      slot = cfg_shape[10*d +: 10];
      return (slot == 10'd0) ? 32'd1 : {22'd0, slot};
   endfunction

   function automatic rsp_payload_type predict_offsets(input logic restart);
      rsp_payload_type r;
      int n;
      int m;
      int i;
      int d;
      logic [7:0] seen;
      logic bad;
      logic carry;
      logic all_last;
      logic [31:0] src_acc;
      logic [31:0] dst_acc;
      logic [63:0] src_sum;
      logic [63:0] dst_sum;
      logic [63:0] prod;
      logic [3:0] eb;

      r = RSP_ZERO;
      n = (cfg_num_dims == 3'd0) ? 1 : ((cfg_num_dims > 3'd6) ? AXES : int'(cfg_num_dims));
      seen = '0;
      bad = 1'b0;
      for (int k = 0; k < n; k++) begin
         m = int'(cfg_map[3*k +: 3]);
         if (m >= n || seen[m]) bad = 1'b1;
         seen[m] = 1'b1;
      end
      if (bad) begin
         walk_on = 1'b0;
         r.bad_config = 1'b1;
         return r;
      end

      if (restart || !walk_on) begin
         for (int k = 0; k < AXES; k++) begin
            stride_src[k] = 32'd1;
            stride_dst[k] = 32'd1;
            axis_pos[k] = 10'd0;
         end
         src_acc = 32'd1;
         dst_acc = 32'd1;
         // Innermost axis first, so each stride is the product of the
         // sizes of the axes inside it.
         for (int k = 0; k < n; k++) begin
            i = n - 1 - k;
            m = int'(cfg_map[3*i +: 3]);
            stride_src[m] = src_acc;
            stride_dst[i] = dst_acc;
            prod = {32'd0, src_acc} * {32'd0, axis_size(m)};
            src_acc = prod[31:0];
            prod = {32'd0, dst_acc} * {32'd0, axis_size(i)};
            dst_acc = prod[31:0];
         end
         walk_on = 1'b1;
      end else begin
         carry = 1'b1;
         for (int k = 0; k < n; k++) begin
            d = n - 1 - k;
            if (carry) begin
               if ({22'd0, axis_pos[d]} + 32'd1 < axis_size(d)) begin
                  axis_pos[d] = axis_pos[d] + 10'd1;
                  carry = 1'b0;
               end else begin
                  axis_pos[d] = 10'd0;
               end
            end
         end
      end

      src_sum = '0;
      dst_sum = '0;
      all_last = 1'b1;
      for (int k = 0; k < n; k++) begin
         src_sum = src_sum + {54'd0, axis_pos[k]} * {32'd0, stride_src[k]};
         dst_sum = dst_sum + {54'd0, axis_pos[k]} * {32'd0, stride_dst[k]};
         if ({22'd0, axis_pos[k]} + 32'd1 != axis_size(k)) all_last = 1'b0;
      end
      eb = (cfg_elem == 4'd0) ? 4'd1 : cfg_elem;
      prod = {32'd0, src_sum[31:0]} * {60'd0, eb};
      r.src_offset = prod[31:0];
      prod = {32'd0, dst_sum[31:0]} * {60'd0, eb};
      r.dst_offset = prod[31:0];
      r.last_element = all_last;
      return r;
   endfunction

   // Model update, register shadowing and response checking, all sampled
   // at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         cfg_num_dims = NUM_DIMS_RESET;
         cfg_shape = DST_SHAPE_RESET;
         cfg_map = AXIS_MAP_RESET;
         cfg_elem = ELEMENT_BYTES_RESET;
         for (int k = 0; k < AXES; k++) begin
            stride_src[k] = 32'd1;
            stride_dst[k] = 32'd1;
            axis_pos[k] = 10'd0;
         end
         walk_on = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = predict_offsets(req_bus.data.restart);
            expected_offsets.push_back(typed_armed ? typed_rsp : predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_offsets.size() == 0) begin
               $error("response transaction arrived with no request outstanding");
               fail_count++;
            end else begin
               want = expected_offsets.pop_front();
               got = rsp_bus.data;
               if (got.src_offset !== want.src_offset) begin
                  $error("src_offset: expected %h, actual %h", want.src_offset, got.src_offset);
                  fail_count++;
               end
               if (got.dst_offset !== want.dst_offset) begin
                  $error("dst_offset: expected %h, actual %h", want.dst_offset, got.dst_offset);
                  fail_count++;
               end
               if (got.last_element !== want.last_element) begin
                  $error("last_element: expected %b, actual %b",
                         want.last_element, got.last_element);
                  fail_count++;
               end
               if (got.bad_config !== want.bad_config) begin
                  $error("bad_config: expected %b, actual %b", want.bad_config, got.bad_config);
                  fail_count++;
               end
               responses_checked++;
               if (want.last_element) walks_finished++;
               if (want.bad_config) bad_maps_flagged++;
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_NUM_DIMS:      cfg_num_dims = csr_wdata[NUM_DIMS_BITS-1:0];
               CSR_DST_SHAPE:     cfg_shape = csr_wdata;
               CSR_AXIS_MAP:      cfg_map = csr_wdata[MAP_BITS-1:0];
               CSR_ELEMENT_BYTES: cfg_elem = csr_wdata[ELEM_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(99, 0) >= rcv_stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
   end

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_item(input logic restart);
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.data.restart = restart;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
      if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
         req_bus.data.restart = 1'($urandom);
         repeat ($urandom_range(6, 0)) @(negedge clock);
      end
   endtask

   // Returns once every response has come back and the block has settled.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_offsets.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // In one call in four, sets bits above the register's width, which the block must drop.
   function automatic logic [CSR_DATA_BITS-1:0] with_noise(input logic [CSR_DATA_BITS-1:0] value,
                                                           input int width);
      logic [CSR_DATA_BITS-1:0] junk;
      junk[59:32] = 28'($urandom);
      junk[31:0] = $urandom;
      if ($urandom_range(3, 0) != 0) return value;
      return value | (junk << width);
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] random_shape(input int used);
      logic [CSR_DATA_BITS-1:0] shape;
      int r;
      shape[59:32] = 28'($urandom);
      shape[31:0] = $urandom;
      // Mostly small axes so walks wrap often; a few zero or large ones.
      for (int d = 0; d < used; d++) begin
         r = $urandom_range(99, 0);
         if (r < 8) shape[10*d +: 10] = 10'd0;
         else if (r < 14) shape[10*d +: 10] = 10'($urandom_range(1023, 1));
         else shape[10*d +: 10] = 10'($urandom_range((used > 4) ? 3 : 4, 1));
      end
      return shape;
   endfunction

   function automatic logic [MAP_BITS-1:0] random_axis_map(input int used, input bit good);
      int perm [AXES];
      int j;
      int t;
      int k;
      logic [MAP_BITS-1:0] word;
      word = 18'($urandom);
      for (int i = 0; i < AXES; i++) perm[i] = i;
      for (int i = used - 1; i > 0; i--) begin
         j = $urandom_range(i, 0);
         t = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      for (int i = 0; i < used; i++) word[3*i +: 3] = 3'(perm[i]);
      if (!good) begin
         k = $urandom_range(used - 1, 0);
         if (used == 1 || $urandom_range(1, 0) == 0)
            word[3*k +: 3] = 3'($urandom_range(7, used));
         else
            word[3*k +: 3] = word[3*((k + 1) % used) +: 3];
      end
      return word;
   endfunction

   task automatic load_random_settings();
      int dims;
      int used;
      logic [ELEM_BITS-1:0] eb;
      if ($urandom_range(9, 0) == 0) dims = ($urandom_range(1, 0) != 0) ? 7 : 0;
      else dims = $urandom_range(6, 1);
      used = (dims == 0) ? 1 : ((dims > AXES) ? AXES : dims);
      eb = ($urandom_range(4, 0) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
      write_reg(CSR_NUM_DIMS, with_noise(60'(dims), NUM_DIMS_BITS));
      write_reg(CSR_DST_SHAPE, random_shape(used));
      write_reg(CSR_AXIS_MAP,
                with_noise(60'(random_axis_map(used, $urandom_range(99, 0) >= 12)), MAP_BITS));
      write_reg(CSR_ELEMENT_BYTES, with_noise(60'(eb), ELEM_BITS));
   endtask

   initial begin
      directed_row_type row;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      typed_armed = 1'b0;
      typed_rsp = RSP_ZERO;
      fail_count = 0;
      requests_sent = 0;
      responses_checked = 0;
      walks_finished = 0;
      bad_maps_flagged = 0;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      hold_requests = 0;
      holds_done = 0;
      hold_left = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         row = DIRECTED_ROWS[r];
         wait_idle();
         if (row.dims != cfg_num_dims) write_reg(CSR_NUM_DIMS, 60'(row.dims));
         if (row.shape != cfg_shape) write_reg(CSR_DST_SHAPE, row.shape);
         if (row.amap != cfg_map) write_reg(CSR_AXIS_MAP, 60'(row.amap));
         if (row.ebytes != cfg_elem) write_reg(CSR_ELEMENT_BYTES, 60'(row.ebytes));
         typed_armed = row.typed;
         typed_rsp = row.exp;
         send_item(row.restart);
      end
      wait_idle();
      typed_armed = 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; rcv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rcv_stall_pct = 81; end
            default: begin send_idle_pct = 30; rcv_stall_pct = 30; end
         endcase
         for (int blk = 0; blk < BLOCKS; blk++) begin
            wait_idle();
            load_random_settings();
            // The sender keeps offering at full rate while the receiver
            // holds off, so the block backs up and stalls its input.
            if (phase == 0 && blk == 0) hold_requests++;
            repeat (BLOCK_ITEMS) send_item($urandom_range(99, 0) < 6);
            if (blk == BLOCKS - 1) begin
               wait_idle();
               write_reg(CSR_DST_SHAPE, random_shape(AXES));
               if ($urandom_range(2, 0) == 0)
                  write_reg(CSR_NUM_DIMS, with_noise(60'($urandom_range(6, 1)), NUM_DIMS_BITS));
               repeat (10) send_item(1'b0);
            end
         end
      end

      wait_idle();
      repeat (END_CYCLES) @(negedge clock);

      $display("Checked %0d responses to %0d requests: %0d directed rows, %0d random phases.",
               responses_checked, requests_sent, DIRECTED_COUNT, PHASES);
      $display("Walks reaching their final element: %0d, bad mappings flagged: %0d.",
               walks_finished, bad_maps_flagged);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/tpag_pkg.sv
rtl/core/tpag_if.sv
rtl/core/tpag_ctrl.sv
rtl/core/tpag_dp.sv
rtl/core/tensor_permute_address_generator_unit.sv
sim/tb_top.sv
